// File: rtl/csle_pkg.sv
// Package for the C string literal escaper.
// Holds the input and output word types, register indexes and character codes.
// No dependencies.
`default_nettype none

package csle_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_literal;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_word_t;

  localparam int RUN_MAX = 7;
  localparam int CNT_W   = $clog2(RUN_MAX + 1);

  localparam logic REG_WRAP_COLUMN  = 1'b0;
  localparam logic REG_START_COLUMN = 1'b1;

  localparam logic [7:0] WRAP_COLUMN_RESET  = 8'd70;
  localparam logic [7:0] START_COLUMN_RESET = 8'd38;

  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_FORMFEED  = 8'h0C;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_APOS      = 8'h27;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_F         = 8'h66;

  localparam logic [7:0] OCT3_MIN = 8'o100;
  localparam logic [7:0] OCT2_MIN = 8'o10;

  function automatic logic [7:0] octal_char(input logic [2:0] digit);
    octal_char = CH_ZERO | {5'b00000, digit};
  endfunction

endpackage

`default_nettype wire

// File: rtl/c_string_literal_escaper.sv
// C string literal escaper, top level.
// Turns raw bytes into escaped literal text, one character per output word.
// Depends on csle_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready/in_word) takes one raw byte per word,
//   with start_literal set on the first byte of a new literal. The output
//   channel (out_valid/out_ready/out_word) gives one character per word, and
//   last_of_run marks the final character produced for an input byte.
//   Each byte yields 1 to 4 characters, 3 more when a line break is inserted,
//   so at most 7.
//   An accepted byte sits in an input register, where its whole
//   run of characters is built and the column and octal flag are updated; the
//   run is loaded into a 7-entry shift register that drains one character
//   per cycle while out_ready is high. The first character of a byte shows
//   once it has passed the input register and the run register. A byte is
//   taken every cycle while each run is one character long and out_ready is
//   high; a longer run holds the input until the single output port drains
//   the run register. The next byte is loaded in the same cycle that the last character of the current run is taken.
//   When the receiver stalls, the run register holds, one byte waits in the
//   input register, and in_ready drops.
//   Synchronous reset empties both stages, clears the column and octal flag,
//   and sets wrap_column to 70 and start_column to 38. The user must write the
//   registers through cfg_write/cfg_index/cfg_data while the block is idle; not enforced.
`default_nettype none

module c_string_literal_escaper (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_write,
  input  wire                  cfg_index,
  input  wire [7:0]            cfg_data,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire csle_pkg::in_word_t in_word,
  output logic                 out_valid,
  input  wire                  out_ready,
  output csle_pkg::out_word_t  out_word
);

  logic [7:0] wrap_column;
  logic [7:0] start_column;
  logic [7:0] column;
  logic [7:0] column_next;
  logic       octal_forbidden;
  logic       octal_forbidden_next;

  logic                 in_reg_valid;
  csle_pkg::in_word_t   in_reg;

  logic [7:0]               run_chars [csle_pkg::RUN_MAX];
  logic [csle_pkg::CNT_W-1:0] run_cnt;

  logic       load;
  logic       pop;
  logic [7:0] c;
  logic [7:0] col_eff;
  logic       forb_eff;
  logic       wrap;
  logic [7:0] esc;
  logic       is_octal;
  logic [7:0] body [4];
  logic [2:0] blen;
  logic [7:0] base;
  logic [8:0] sum;
  logic [7:0] load_chars [csle_pkg::RUN_MAX];
  logic [csle_pkg::CNT_W-1:0] load_cnt;

  assign pop      = out_valid && out_ready;
  assign load     = in_reg_valid && (run_cnt == '0 || (run_cnt == 1 && out_ready));
  assign in_ready = !in_reg_valid || load;

  assign out_valid            = run_cnt != '0;
  assign out_word.out_char    = run_chars[0];
  assign out_word.last_of_run = run_cnt == 1;

  always_comb begin
    c        = in_reg.data_byte;
    col_eff  = in_reg.start_literal ? start_column : column;
    forb_eff = in_reg.start_literal ? 1'b0 : octal_forbidden;
    wrap     = col_eff >= wrap_column;

    case (c)
      csle_pkg::CH_NEWLINE:   esc = csle_pkg::CH_N;
      csle_pkg::CH_TAB:       esc = csle_pkg::CH_T;
      csle_pkg::CH_BACKSPACE: esc = csle_pkg::CH_B;
      csle_pkg::CH_RETURN:    esc = csle_pkg::CH_R;
      csle_pkg::CH_FORMFEED:  esc = csle_pkg::CH_F;
      csle_pkg::CH_BACKSLASH: esc = csle_pkg::CH_BACKSLASH;
      csle_pkg::CH_APOS:      esc = csle_pkg::CH_APOS;
      default:                esc = 8'h00;
    endcase

    is_octal = c < csle_pkg::CH_SPACE || c == csle_pkg::CH_DQUOTE ||
               c == csle_pkg::CH_QUESTION || c > csle_pkg::CH_TILDE ||
               (c >= csle_pkg::CH_ZERO && c <= csle_pkg::CH_SEVEN && forb_eff);

    body[0] = csle_pkg::CH_BACKSLASH;
    body[1] = csle_pkg::octal_char(c[2:0]);
    body[2] = csle_pkg::octal_char(c[2:0]);
    body[3] = csle_pkg::octal_char(c[2:0]);
    octal_forbidden_next = 1'b0;
    if (esc != 8'h00) begin
      body[1] = esc;
      blen    = 3'd2;
    end else if (is_octal) begin
      octal_forbidden_next = c < csle_pkg::OCT3_MIN;
      if (c >= csle_pkg::OCT3_MIN) begin
        body[1] = csle_pkg::octal_char({1'b0, c[7:6]});
        body[2] = csle_pkg::octal_char(c[5:3]);
        blen    = 3'd4;
      end else if (c >= csle_pkg::OCT2_MIN) begin
        body[1] = csle_pkg::octal_char(c[5:3]);
        blen    = 3'd3;
      end else begin
        blen    = 3'd2;
      end
    end else begin
      body[0] = c;
      blen    = 3'd1;
    end

    base        = wrap ? 8'd0 : col_eff;
    sum         = {1'b0, base} + {6'd0, blen};
    column_next = sum[8] ? 8'hFF : sum[7:0];

    if (wrap) begin
      load_chars[0] = csle_pkg::CH_DQUOTE;
      load_chars[1] = csle_pkg::CH_NEWLINE;
      load_chars[2] = csle_pkg::CH_DQUOTE;
      load_chars[3] = body[0];
      load_chars[4] = body[1];
      load_chars[5] = body[2];
      load_chars[6] = body[3];
      load_cnt      = csle_pkg::CNT_W'(blen) + csle_pkg::CNT_W'(3);
    end else begin
      load_chars[0] = body[0];
      load_chars[1] = body[1];
      load_chars[2] = body[2];
      load_chars[3] = body[3];
      load_chars[4] = body[3];
      load_chars[5] = body[3];
      load_chars[6] = body[3];
      load_cnt      = csle_pkg::CNT_W'(blen);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_column  <= csle_pkg::WRAP_COLUMN_RESET;
      start_column <= csle_pkg::START_COLUMN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        csle_pkg::REG_WRAP_COLUMN:  wrap_column  <= cfg_data;
        csle_pkg::REG_START_COLUMN: start_column <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid    <= 1'b0;
      run_cnt         <= '0;
      column          <= 8'd0;
      octal_forbidden <= 1'b0;
    end else begin
      if (in_ready) begin
        in_reg_valid <= in_valid;
      end
      if (load) begin
        run_cnt         <= load_cnt;
        column          <= column_next;
        octal_forbidden <= octal_forbidden_next;
      end else if (pop) begin
        run_cnt <= run_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg <= in_word;
    end
    if (load) begin
      run_chars <= load_chars;
    end else if (pop) begin
      for (int i = 0; i < csle_pkg::RUN_MAX - 1; i++) begin
        run_chars[i] <= run_chars[i + 1];
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    run_cnt <= csle_pkg::CNT_W'(csle_pkg::RUN_MAX))
    else $error("run count exceeds run length");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded run not presented");

  a_run_holds: assert property (@(posedge clk) disable iff (rst)
    (pop && !out_word.last_of_run) |=> out_valid)
    else $error("run ended before its last character");

  a_load_only_at_end: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || (out_ready && out_word.last_of_run)))
    else $error("run overwritten before it drained");

  a_flag_column: assert property (@(posedge clk) disable iff (rst)
    octal_forbidden |-> column >= 8'd2)
    else $error("octal flag set with too small a column");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Testbench for c_string_literal_escaper: random and directed bytes under
// handshake pressure, with every output character checked against a predictor.
// Depends on csle_pkg and the c_string_literal_escaper RTL.

module testbench;
  import csle_pkg::*;

  class escape_board;
    out_word_t   expected_chars[$];
    int          errors = 0;
    logic [7:0]  wrap_at = WRAP_COLUMN_RESET;
    logic [7:0]  start_at = START_COLUMN_RESET;
    logic [7:0]  col = 8'd0;
    logic        octal_locked = 1'b0;

    task report(string what);
      errors++;
      if (errors <= 200) $display("MISMATCH: %s", what);
    endtask

    function void set_register(logic idx, logic [7:0] value);
      if (idx == REG_WRAP_COLUMN) wrap_at = value;
      else start_at = value;
    endfunction

    function void bump(int n);
      int v;
      v = col + n;
      col = (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function logic [7:0] digit(logic [2:0] d);
      return CH_ZERO + {5'b00000, d};
    endfunction

    function void note_byte(in_word_t w);
      logic [7:0] c;
      logic [7:0] esc;
      logic [7:0] run[$];
      c = w.data_byte;
      esc = 8'd0;
      if (w.start_literal) begin
        col = start_at;
        octal_locked = 1'b0;
      end
      if (col >= wrap_at) begin
        run.push_back(CH_DQUOTE);
        run.push_back(CH_NEWLINE);
        run.push_back(CH_DQUOTE);
        col = 8'd0;
      end
      case (c)
        CH_NEWLINE:   esc = CH_N;
        CH_TAB:       esc = CH_T;
        CH_BACKSPACE: esc = CH_B;
        CH_RETURN:    esc = CH_R;
        CH_FORMFEED:  esc = CH_F;
        CH_BACKSLASH: esc = CH_BACKSLASH;
        CH_APOS:      esc = CH_APOS;
        default:      esc = 8'd0;
      endcase
      if (esc != 8'd0) begin
        run.push_back(CH_BACKSLASH);
        run.push_back(esc);
        bump(2);
        octal_locked = 1'b0;
      end else if (c < CH_SPACE || c == CH_DQUOTE || c == CH_QUESTION || c > CH_TILDE ||
                   (c >= CH_ZERO && c <= CH_SEVEN && octal_locked)) begin
        run.push_back(CH_BACKSLASH);
        if (c >= OCT3_MIN) begin
          run.push_back(digit({1'b0, c[7:6]}));
          run.push_back(digit(c[5:3]));
          run.push_back(digit(c[2:0]));
          bump(4);
        end else if (c >= OCT2_MIN) begin
          run.push_back(digit(c[5:3]));
          run.push_back(digit(c[2:0]));
          bump(3);
        end else begin
          run.push_back(digit(c[2:0]));
          bump(2);
        end
        octal_locked = (c < OCT3_MIN);
      end else begin
        run.push_back(c);
        bump(1);
        octal_locked = 1'b0;
      end
      foreach (run[i]) begin
        out_word_t o;
        o.out_char = run[i];
        o.last_of_run = (i == run.size() - 1);
        expected_chars.push_back(o);
      end
    endfunction

    task check_char(out_word_t got);
      out_word_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("character 0x%02h with none expected", got.out_char));
      end else begin
        want = expected_chars.pop_front();
        if (got.out_char !== want.out_char)
          report($sformatf("out_char 0x%02h, expected 0x%02h", got.out_char, want.out_char));
        if (got.last_of_run !== want.last_of_run)
          report($sformatf("last_of_run %0b, expected %0b on char 0x%02h",
                           got.last_of_run, want.last_of_run, want.out_char));
      end
    endtask
  endclass

  logic      clk;
  logic      rst;
  logic      cfg_write;
  logic      cfg_index;
  logic [7:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  escape_board board = new();
  int burst_left = 0;
  int rx_cycle = 0;

  c_string_literal_escaper dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // The receiver cycles through always ready, random, sparse and mostly ready.
  always @(negedge clk) begin
    rx_cycle++;
    case ((rx_cycle / 50) % 4)
      0: out_ready = 1'b1;
      1: out_ready = 1'($urandom_range(0, 1));
      2: out_ready = (rx_cycle % 5 == 0);
      default: out_ready = ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_char(out_word);
  end

  task automatic write_register(logic idx, logic [7:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    board.set_register(idx, value);
  endtask

  task automatic configure(logic [7:0] wrap_value, logic [7:0] start_value);
    write_register(REG_WRAP_COLUMN, wrap_value);
    write_register(REG_START_COLUMN, start_value);
  endtask

  task automatic send_item(logic [7:0] b, logic s);
    in_word_t w;
    int gap;
    w.data_byte = b;
    w.start_literal = s;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (!in_ready);
    board.note_byte(w);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    burst_left = 0;
    while (board.expected_chars.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(0, 255));
      4, 5:       return 8'($urandom_range(CH_SPACE, CH_TILDE));
      6, 7:       return 8'($urandom_range(CH_ZERO, CH_ZERO + 9));
      8:          return 8'($urandom_range(0, CH_SPACE - 1));
      default: begin
        case ($urandom_range(0, 6))
          0: return CH_NEWLINE;
          1: return CH_TAB;
          2: return CH_BACKSPACE;
          3: return CH_RETURN;
          4: return CH_FORMFEED;
          5: return CH_BACKSLASH;
          default: return CH_APOS;
        endcase
      end
    endcase
  endfunction

  task automatic random_phase(logic [7:0] wrap_value, logic [7:0] start_value, int count);
    configure(wrap_value, start_value);
    send_item(random_byte(), 1'b1);
    repeat (count - 1) send_item(random_byte(), ($urandom_range(0, 15) == 0));
    drain();
  endtask

  initial begin
    logic [7:0] directed[$];
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_WRAP_COLUMN;
    cfg_data = 8'd0;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: every escape, octal lengths, and digits after a short octal escape.
    directed = '{8'h41, CH_NEWLINE, CH_TAB, CH_BACKSPACE, CH_RETURN, CH_FORMFEED,
                 CH_BACKSLASH, CH_APOS, 8'h00, CH_ZERO, CH_SEVEN, 8'h1F, 8'h38,
                 CH_ZERO, CH_DQUOTE, CH_QUESTION, 8'h35, CH_TILDE, 8'h7F, 8'hFF,
                 CH_SPACE, 8'h80};
    foreach (directed[i]) send_item(directed[i], (i == 0));
    drain();

    // Column saturation at the top of the range.
    configure(8'd255, 8'd250);
    send_item(8'h80, 1'b1);
    send_item(8'hC0, 1'b0);
    send_item(8'h41, 1'b0);
    drain();

    // A wrap column of zero breaks before every byte; a start beyond wrap breaks at once.
    configure(8'd0, 8'd0);
    send_item(8'h61, 1'b1);
    send_item(8'h07, 1'b0);
    drain();
    configure(8'd10, 8'd200);
    send_item(8'h62, 1'b1);
    drain();

    random_phase(8'd1, 8'd0, 25);
    random_phase(8'd250, 8'd0, 25);
    random_phase(8'd250, 8'd250, 25);
    random_phase(8'd8, 8'd2, 25);
    random_phase(8'($urandom_range(1, 250)), 8'($urandom_range(0, 250)), 25);
    random_phase(8'd40, 8'd20, 25);

    repeat (10) @(negedge clk);
    if (board.errors == 0 && board.expected_chars.size() == 0) begin
      $display("c_string_literal_escaper test passed");
    end else begin
      $display("c_string_literal_escaper test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("c_string_literal_escaper test failed");
    $finish;
  end

endmodule
